>>> sv/infix_expression_evaluator_macros.svh
// Assertion helpers used by the evaluator back end (iee_back).
`ifndef INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define IEE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define IEE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/iee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_pkg
// Shared constants, token type and helpers of the expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    // token kinds
    localparam logic [3:0] K_DIGIT = 4'd0;
    localparam logic [3:0] K_SPACE = 4'd1;
    localparam logic [3:0] K_PLUS  = 4'd2;
    localparam logic [3:0] K_MINUS = 4'd3;
    localparam logic [3:0] K_STAR  = 4'd4;
    localparam logic [3:0] K_SLASH = 4'd5;
    localparam logic [3:0] K_LPAR  = 4'd6;
    localparam logic [3:0] K_RPAR  = 4'd7;
    localparam logic [3:0] K_OTHER = 4'd8;

    // operator stack codes
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_LPAR = 3'd4;
    localparam logic [2:0] OP_NEG  = 3'd5;

    // parse phases
    localparam logic [1:0] PH_OPERAND  = 2'd0;
    localparam logic [1:0] PH_NUMBER   = 2'd1;
    localparam logic [1:0] PH_OPERATOR = 2'd2;
    localparam logic [1:0] PH_DONE     = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SYNTAX = 2'd1;
    localparam logic [1:0] ST_DIV0   = 2'd2;
    localparam logic [1:0] ST_DEEP   = 2'd3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [3:0] kind;
        logic [3:0] digit;
        logic       last;
    } t_tok;

    function automatic logic [1:0] prec(input logic [2:0] op);
        logic [1:0] p;
        p = 2'd0;
        if (op == OP_ADD || op == OP_SUB) p = 2'd1;
        if (op == OP_MUL || op == OP_DIV) p = 2'd2;
        return p;
    endfunction

endpackage

>>> sv/iee_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/iee_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_front
// Accepts characters, classifies them into tokens, queues two tokens.
// ----------------------------------------------------------------------------
module iee_front
    import iee_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_tok_valid,
    output t_tok       o_tok,
    input  logic       i_tok_pop
);

    t_tok       tok_c;
    t_tok       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    always_comb begin
        tok_c.digit = 4'(i_ch - CH_ZERO);
        tok_c.last  = i_last;
        if (i_ch >= CH_ZERO && i_ch <= CH_NINE) begin
            tok_c.kind = K_DIGIT;
        end else begin
            unique case (i_ch)
                CH_SPACE: tok_c.kind = K_SPACE;
                CH_PLUS:  tok_c.kind = K_PLUS;
                CH_MINUS: tok_c.kind = K_MINUS;
                CH_STAR:  tok_c.kind = K_STAR;
                CH_SLASH: tok_c.kind = K_SLASH;
                CH_LPAR:  tok_c.kind = K_LPAR;
                CH_RPAR:  tok_c.kind = K_RPAR;
                default:  tok_c.kind = K_OTHER;
            endcase
        end
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_tok_valid = (r_cnt != 2'd0);
    assign pop         = i_tok_pop && o_tok_valid;
    assign o_tok       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_q[r_wp] <= tok_c;
        end
    end

endmodule

>>> sv/iee_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_back
// Stack sequencer: operand RAM, operator stack, reductions and divider.
// ----------------------------------------------------------------------------
`include "infix_expression_evaluator_macros.svh"

module iee_back
    import iee_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tok_valid,
    input  t_tok        i_tok,
    output logic        o_tok_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_FIN     = 4'd2;
    localparam logic [3:0] S_RED     = 4'd3;
    localparam logic [3:0] S_APPLY   = 4'd4;
    localparam logic [3:0] S_DIV     = 4'd5;
    localparam logic [3:0] S_DIVFIN  = 4'd6;
    localparam logic [3:0] S_LASTCHK = 4'd7;
    localparam logic [3:0] S_FINAL   = 4'd8;
    localparam logic [3:0] S_VAL     = 4'd9;

    localparam logic [1:0] AFT_PUSHOP = 2'd0;
    localparam logic [1:0] AFT_RPAR   = 2'd1;
    localparam logic [1:0] AFT_DONE   = 2'd2;

    localparam logic [1:0] FIN_TOKEN = 2'd0;
    localparam logic [1:0] FIN_ITEM  = 2'd1;
    localparam logic [1:0] FIN_LAST  = 2'd2;

    logic [3:0]       r_state, n_state;
    t_tok             r_tok, n_tok;
    logic [1:0]       r_phase, n_phase;
    logic [1:0]       r_err, n_err;
    logic [31:0]      r_accum, n_accum;
    logic [31:0]      r_tos, n_tos;
    logic [CNT_W-1:0] r_ncnt, n_ncnt;
    logic [CNT_W-1:0] r_opcnt, n_opcnt;
    logic [CNT_W-1:0] r_lpar, n_lpar;
    logic [1:0]       r_minp, n_minp;
    logic [1:0]       r_after, n_after;
    logic [1:0]       r_fin_after, n_fin_after;
    logic [2:0]       r_pend, n_pend;
    logic             r_final, n_final;
    logic [2:0]       r_op, n_op;
    logic [31:0]      r_dq, n_dq;
    logic [31:0]      r_dm, n_dm;
    logic [31:0]      r_rem, n_rem;
    logic [4:0]       r_dcnt, n_dcnt;
    logic             r_dneg, n_dneg;
    logic             r_ovalid, n_ovalid;
    logic [31:0]      r_value, n_value;
    logic [1:0]       r_status, n_status;

    logic [2:0]       r_ops [STACK_DEPTH];
    logic             op_we;
    logic [2:0]       op_wd;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [31:0]      ram_wdata, ram_rdata;

    logic [CNT_W-1:0] ncnt_m1, ncnt_m2, opcnt_m1;
    logic [2:0]       top_op;
    logic [31:0]      a_val, res_c;
    logic [32:0]      rem_sh, rem_diff;
    logic [1:0]       fin_status;
    logic             out_free;

    assign ncnt_m1  = r_ncnt - CNT_W'(1);
    assign ncnt_m2  = r_ncnt - CNT_W'(2);
    assign opcnt_m1 = r_opcnt - CNT_W'(1);
    assign top_op   = r_ops[opcnt_m1[IDX_W-1:0]];
    assign a_val    = ram_rdata;
    assign ram_raddr = ncnt_m2[IDX_W-1:0];
    assign rem_sh   = {r_rem, r_dq[31]};
    assign rem_diff = rem_sh - {1'b0, r_dm};
    assign out_free = !r_ovalid || i_ready;
    assign fin_status = (r_err != ST_OK) ? r_err : ((r_ncnt == '0) ? ST_SYNTAX : ST_OK);

    iee_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_opnd_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;   n_tok = r_tok;       n_phase = r_phase;
        n_err = r_err;       n_accum = r_accum;   n_tos = r_tos;
        n_ncnt = r_ncnt;     n_opcnt = r_opcnt;   n_lpar = r_lpar;
        n_minp = r_minp;     n_after = r_after;   n_fin_after = r_fin_after;
        n_pend = r_pend;     n_final = r_final;   n_op = r_op;
        n_dq = r_dq;         n_dm = r_dm;         n_rem = r_rem;
        n_dcnt = r_dcnt;     n_dneg = r_dneg;
        n_ovalid = r_ovalid && !i_ready;
        n_value = r_value;   n_status = r_status;
        op_we = 1'b0;        op_wd = OP_ADD;
        ram_we = 1'b0;       ram_waddr = r_ncnt[IDX_W-1:0];  ram_wdata = r_accum;
        o_tok_pop = 1'b0;
        res_c = 32'd0;

        unique case (r_state)
            S_IDLE: begin
                if (i_tok_valid) begin
                    o_tok_pop = 1'b1;
                    n_tok     = i_tok;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_LASTCHK;
                if (r_err != ST_OK || r_phase == PH_DONE) begin
                    n_state = S_LASTCHK;
                end else if (r_phase == PH_NUMBER) begin
                    if (r_tok.kind == K_DIGIT) begin
                        n_accum = (r_accum << 3) + (r_accum << 1) + {28'd0, r_tok.digit};
                    end else if (r_ncnt == CNT_W'(STACK_DEPTH)) begin
                        n_err = ST_DEEP;
                    end else begin
                        ram_we      = 1'b1;
                        n_tos       = r_accum;
                        n_ncnt      = r_ncnt + CNT_W'(1);
                        n_fin_after = FIN_TOKEN;
                        n_state     = S_FIN;
                    end
                end else if (r_phase == PH_OPERAND) begin
                    priority case (r_tok.kind)
                        K_SPACE: ;
                        K_DIGIT: begin
                            n_accum = {28'd0, r_tok.digit};
                            n_phase = PH_NUMBER;
                        end
                        K_LPAR, K_MINUS: begin
                            if (r_opcnt == CNT_W'(STACK_DEPTH)) begin
                                n_err = ST_DEEP;
                            end else begin
                                op_we   = 1'b1;
                                op_wd   = (r_tok.kind == K_LPAR) ? OP_LPAR : OP_NEG;
                                n_opcnt = r_opcnt + CNT_W'(1);
                                if (r_tok.kind == K_LPAR) n_lpar = r_lpar + CNT_W'(1);
                            end
                        end
                        default: n_err = ST_SYNTAX;
                    endcase
                end else begin
                    priority case (r_tok.kind)
                        K_SPACE: ;
                        K_PLUS, K_MINUS: begin
                            n_minp  = 2'd1;
                            n_after = AFT_PUSHOP;
                            n_pend  = (r_tok.kind == K_PLUS) ? OP_ADD : OP_SUB;
                            n_state = S_RED;
                        end
                        K_STAR, K_SLASH: begin
                            n_minp  = 2'd2;
                            n_after = AFT_PUSHOP;
                            n_pend  = (r_tok.kind == K_STAR) ? OP_MUL : OP_DIV;
                            n_state = S_RED;
                        end
                        K_RPAR: begin
                            n_minp  = 2'd1;
                            n_after = AFT_RPAR;
                            n_state = S_RED;
                        end
                        default: begin
                            if (r_lpar != '0) begin
                                n_err = ST_SYNTAX;
                            end else begin
                                n_minp  = 2'd1;
                                n_after = AFT_DONE;
                                n_state = S_RED;
                            end
                        end
                    endcase
                end
            end
            S_FIN: begin
                // pop pending unary minus one at a time
                if (r_opcnt != '0 && top_op == OP_NEG) begin
                    n_opcnt = opcnt_m1;
                    if (r_ncnt != '0) begin
                        n_tos     = 32'd0 - r_tos;
                        ram_we    = 1'b1;
                        ram_waddr = ncnt_m1[IDX_W-1:0];
                        ram_wdata = 32'd0 - r_tos;
                    end else if (r_err == ST_OK) begin
                        n_err = ST_SYNTAX;
                    end
                end else begin
                    n_phase = PH_OPERATOR;
                    unique case (r_fin_after)
                        FIN_TOKEN: n_state = (r_err != ST_OK) ? S_LASTCHK : S_DISP;
                        FIN_ITEM:  n_state = S_LASTCHK;
                        default:   n_state = S_FINAL;
                    endcase
                end
            end
            S_RED: begin
                if (r_err == ST_OK && r_opcnt != '0 && prec(top_op) != 2'd0
                        && prec(top_op) >= r_minp) begin
                    n_opcnt = opcnt_m1;
                    n_op    = top_op;
                    if (r_ncnt < CNT_W'(2)) begin
                        n_err = ST_SYNTAX;
                    end else begin
                        n_state = S_APPLY;
                    end
                end else begin
                    unique case (r_after)
                        AFT_PUSHOP: begin
                            if (r_opcnt == CNT_W'(STACK_DEPTH)) begin
                                if (r_err == ST_OK) n_err = ST_DEEP;
                            end else begin
                                op_we   = 1'b1;
                                op_wd   = r_pend;
                                n_opcnt = r_opcnt + CNT_W'(1);
                            end
                            n_phase = PH_OPERAND;
                            n_state = S_LASTCHK;
                        end
                        AFT_RPAR: begin
                            n_state = S_LASTCHK;
                            if (r_err == ST_OK) begin
                                if (r_opcnt != '0 && top_op == OP_LPAR) begin
                                    n_opcnt     = opcnt_m1;
                                    n_lpar      = r_lpar - CNT_W'(1);
                                    n_fin_after = FIN_ITEM;
                                    n_state     = S_FIN;
                                end else begin
                                    if (r_opcnt != '0) n_err = ST_SYNTAX;
                                    n_phase = PH_DONE;
                                end
                            end
                        end
                        default: begin
                            if (r_err == ST_OK && r_opcnt != '0) n_err = ST_SYNTAX;
                            n_phase = PH_DONE;
                            n_state = r_final ? S_VAL : S_LASTCHK;
                        end
                    endcase
                end
            end
            S_APPLY: begin
                priority case (r_op)
                    OP_ADD: res_c = a_val + r_tos;
                    OP_SUB: res_c = a_val - r_tos;
                    OP_MUL: res_c = a_val * r_tos;
                    default: res_c = 32'd0;
                endcase
                if (r_op == OP_DIV) begin
                    if (r_tos == 32'd0) begin
                        n_err   = ST_DIV0;
                        n_state = S_RED;
                    end else begin
                        n_dq    = a_val[31] ? 32'd0 - a_val : a_val;
                        n_dm    = r_tos[31] ? 32'd0 - r_tos : r_tos;
                        n_rem   = 32'd0;
                        n_dcnt  = 5'd0;
                        n_dneg  = a_val[31] ^ r_tos[31];
                        n_state = S_DIV;
                    end
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = ncnt_m2[IDX_W-1:0];
                    ram_wdata = res_c;
                    n_tos     = res_c;
                    n_ncnt    = ncnt_m1;
                    n_state   = S_RED;
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                if (!rem_diff[32]) begin
                    n_rem = rem_diff[31:0];
                    n_dq  = {r_dq[30:0], 1'b1};
                end else begin
                    n_rem = rem_sh[31:0];
                    n_dq  = {r_dq[30:0], 1'b0};
                end
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'd31) n_state = S_DIVFIN;
            end
            S_DIVFIN: begin
                res_c     = r_dneg ? 32'd0 - r_dq : r_dq;
                ram_we    = 1'b1;
                ram_waddr = ncnt_m2[IDX_W-1:0];
                ram_wdata = res_c;
                n_tos     = res_c;
                n_ncnt    = ncnt_m1;
                n_state   = S_RED;
            end
            S_LASTCHK: begin
                n_state = r_tok.last ? S_FINAL : S_IDLE;
            end
            S_FINAL: begin
                n_final = 1'b1;
                n_state = S_VAL;
                if (r_err == ST_OK) begin
                    unique case (r_phase)
                        PH_NUMBER: begin
                            if (r_ncnt == CNT_W'(STACK_DEPTH)) begin
                                n_err = ST_DEEP;
                            end else begin
                                ram_we      = 1'b1;
                                n_tos       = r_accum;
                                n_ncnt      = r_ncnt + CNT_W'(1);
                                n_fin_after = FIN_LAST;
                                n_state     = S_FIN;
                            end
                        end
                        PH_OPERAND: n_err = ST_SYNTAX;
                        PH_OPERATOR: begin
                            if (r_lpar != '0) begin
                                n_err = ST_SYNTAX;
                            end else begin
                                n_minp  = 2'd1;
                                n_after = AFT_DONE;
                                n_state = S_RED;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_VAL: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_status = fin_status;
                    n_value  = (fin_status == ST_OK) ? r_tos : 32'd0;
                    n_phase  = PH_OPERAND;
                    n_err    = ST_OK;
                    n_accum  = 32'd0;
                    n_ncnt   = '0;
                    n_opcnt  = '0;
                    n_lpar   = '0;
                    n_final  = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_OPERAND;
            r_err    <= ST_OK;
            r_accum  <= 32'd0;
            r_ncnt   <= '0;
            r_opcnt  <= '0;
            r_lpar   <= '0;
            r_final  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_err    <= n_err;
            r_accum  <= n_accum;
            r_ncnt   <= n_ncnt;
            r_opcnt  <= n_opcnt;
            r_lpar   <= n_lpar;
            r_final  <= n_final;
            r_ovalid <= n_ovalid;
        end
        r_tok       <= n_tok;
        r_tos       <= n_tos;
        r_minp      <= n_minp;
        r_after     <= n_after;
        r_fin_after <= n_fin_after;
        r_pend      <= n_pend;
        r_op        <= n_op;
        r_dq        <= n_dq;
        r_dm        <= n_dm;
        r_rem       <= n_rem;
        r_dcnt      <= n_dcnt;
        r_dneg      <= n_dneg;
        r_value     <= n_value;
        r_status    <= n_status;
        if (op_we) begin
            r_ops[r_opcnt[IDX_W-1:0]] <= op_wd;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_value  = r_value;
    assign o_status = r_status;

    `IEE_ASSERT(a_cnt_bound, r_ncnt <= CNT_W'(STACK_DEPTH) && r_opcnt <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
    `IEE_ASSERT(a_lpar_bound, r_lpar <= r_opcnt, "open parens exceed operator count")
    `IEE_ASSERT_NEXT(a_emit_clears, r_state == S_VAL && out_free, r_ovalid && r_ncnt == '0 && r_err == ST_OK, "result emit did not clear state")
    `IEE_ASSERT_NEXT(a_div_len, r_state == S_DIV && r_dcnt != 5'd31, r_state == S_DIV, "divider left early")

endmodule

>>> sv/infix_expression_evaluator.sv
`timescale 1ns / 1ps
// Each character is popped from the front queue and dispatched; each reduction
// reads the operand RAM, then applies; a division runs a 32-step divider.
// The result is registered out after the last item finishes its reductions.
// Throughput: one item at a time in the back end, front queues two items.
// Reset: synchronous active-low i_rst_n clears control; stacks are not cleared.
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Streams an expression line one character per item and emits value/status.
// ----------------------------------------------------------------------------
module infix_expression_evaluator
    import iee_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);

    logic tok_valid, tok_pop;
    t_tok tok;

    iee_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .o_tok_valid (tok_valid),
        .o_tok       (tok),
        .i_tok_pop   (tok_pop)
    );

    iee_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .i_tok       (tok),
        .o_tok_pop   (tok_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_status    (o_status)
    );

endmodule
